>>> hdl/pcsp_pkg.sv
// Package for the pin command stream parser: item and result types,
// character codes, result kinds and limits. No dependencies.
`timescale 1ns / 1ps

package pcsp_pkg;

   // Input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_DIGITAL = 2'd0;
   localparam logic [1:0] KIND_ANALOG  = 2'd1;
   localparam logic [1:0] KIND_VIRTUAL = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // Characters of the command grammar
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Saturation limits
   localparam logic [7:0]  ADDR_MAX   = 8'd255;
   localparam logic [15:0] MAG_MAX    = 16'd32768;
   localparam logic [15:0] VALUE_MAX  = 16'd32767;
   localparam logic [15:0] ANALOG_MAX = 16'd255;

   // Configuration register map
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd3000;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } pcsp_item_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  result_kind;
      logic [7:0]  pin_number;
      logic [15:0] pin_data;
   } pcsp_result_type;

endpackage

>>> hdl/pcsp_csr.sv
// APB-style configuration register of the pin command stream parser.
// Holds the timeout limit; depends on pcsp_pkg.
`timescale 1ns / 1ps

module pcsp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcsp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic [15:0]                        timeout_ticks
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        reg_index;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;

   // Decode the write access cycle
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (reg_index == pcsp_pkg::CSR_IDX_TIMEOUT)) begin
         timeout_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pcsp_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Return the register value on reads
   always_comb begin
      csr_prdata = 32'd0;
      if (reg_index == pcsp_pkg::CSR_IDX_TIMEOUT) begin
         csr_prdata = {16'd0, timeout_ff};
      end
   end

   assign timeout_ticks = timeout_ff;

endmodule

>>> hdl/pcsp_parser.sv
// Parser state and next-state logic for the pin command grammar.
// Takes one registered item per advance; depends on pcsp_pkg.
`timescale 1ns / 1ps

module pcsp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  pcsp_pkg::pcsp_item_type   item,
   input  logic [15:0]               timeout_ticks,
   output pcsp_pkg::pcsp_result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ADDR,
      PH_VALUE
   } phase_type;

   phase_type   phase_ff,   phase_in;
   logic [1:0]  kind_ff,    kind_in;
   logic [7:0]  addr_ff,    addr_in;
   logic [15:0] value_ff,   value_in;
   logic        minus_ff,   minus_in;
   logic        digit_ff,   digit_in;
   logic        timer_ff,   timer_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic        is_digit;
   logic        started;
   logic [3:0]  digit;
   logic [11:0] addr_mul;
   logic [7:0]  addr_sat;
   logic [18:0] value_mul;
   logic [15:0] value_sat;
   logic [15:0] value_pos;
   logic [15:0] value_out;
   logic        is_type;

   // Decode the byte and accumulate one decimal digit
   always_comb begin
      is_digit  = (item.rx_byte >= pcsp_pkg::CHAR_ZERO) &&
                  (item.rx_byte <= pcsp_pkg::CHAR_NINE);
      started   = minus_ff || digit_ff;
      digit     = item.rx_byte[3:0];
      addr_mul  = {1'b0, addr_ff, 3'd0} + {3'd0, addr_ff, 1'b0} + {8'd0, digit};
      addr_sat  = (addr_mul > {4'd0, pcsp_pkg::ADDR_MAX}) ? pcsp_pkg::ADDR_MAX
                                                          : addr_mul[7:0];
      value_mul = {value_ff, 3'd0} + {2'd0, value_ff, 1'b0} + {15'd0, digit};
      value_sat = (value_mul > {3'd0, pcsp_pkg::MAG_MAX}) ? pcsp_pkg::MAG_MAX
                                                          : value_mul[15:0];
      is_type   = (item.rx_byte == pcsp_pkg::CHAR_D) ||
                  (item.rx_byte == pcsp_pkg::CHAR_A) ||
                  (item.rx_byte == pcsp_pkg::CHAR_V);
   end

   // Form the signed value: negate, saturate, clamp analog
   always_comb begin
      value_pos = (value_ff > pcsp_pkg::VALUE_MAX) ? pcsp_pkg::VALUE_MAX : value_ff;
      if (minus_ff) begin
         value_out = 16'd0 - value_ff;
      end else if ((kind_ff == pcsp_pkg::KIND_ANALOG) &&
                   (value_pos > pcsp_pkg::ANALOG_MAX)) begin
         value_out = pcsp_pkg::ANALOG_MAX;
      end else begin
         value_out = value_pos;
      end
   end

   // Advance the parser by one transaction
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      addr_in    = addr_ff;
      value_in   = value_ff;
      minus_in   = minus_ff;
      digit_in   = digit_ff;
      timer_in   = timer_ff;
      elapsed_in = elapsed_ff;
      result     = '0;
      if (advance) begin
         if (item.opcode == pcsp_pkg::OP_TICK) begin
            if (timer_ff) begin
               if (elapsed_ff >= timeout_ticks) begin
                  phase_in           = PH_IDLE;
                  timer_in           = 1'b0;
                  elapsed_in         = 16'd0;
                  minus_in           = 1'b0;
                  digit_in           = 1'b0;
                  result.valid       = 1'b1;
                  result.result_kind = pcsp_pkg::KIND_TIMEOUT;
               end else begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
            end
         end else begin
            case (phase_ff)
               PH_ADDR: begin
                  if (is_digit) begin
                     addr_in  = addr_sat;
                     digit_in = 1'b1;
                  end else if (!started) begin
                     if (item.rx_byte == pcsp_pkg::CHAR_MINUS) begin
                        minus_in = 1'b1;
                     end
                  end else begin
                     // Number ended: a negative address reads as zero
                     if (minus_ff) begin
                        addr_in = 8'd0;
                     end
                     minus_in = 1'b0;
                     digit_in = 1'b0;
                     if (item.rx_byte == pcsp_pkg::CHAR_HASH) begin
                        phase_in = PH_VALUE;
                        value_in = 16'd0;
                     end else begin
                        phase_in   = PH_IDLE;
                        timer_in   = 1'b0;
                        elapsed_in = 16'd0;
                     end
                  end
               end
               PH_VALUE: begin
                  if (is_digit) begin
                     value_in = value_sat;
                     digit_in = 1'b1;
                  end else if (!started) begin
                     if (item.rx_byte == pcsp_pkg::CHAR_MINUS) begin
                        minus_in = 1'b1;
                     end
                  end else begin
                     phase_in   = PH_IDLE;
                     timer_in   = 1'b0;
                     elapsed_in = 16'd0;
                     minus_in   = 1'b0;
                     digit_in   = 1'b0;
                     if (item.rx_byte == pcsp_pkg::CHAR_STAR) begin
                        result.valid       = 1'b1;
                        result.result_kind = kind_ff;
                        result.pin_number  = addr_ff;
                        result.pin_data    = value_out;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  if (is_type) begin
                     if (item.rx_byte == pcsp_pkg::CHAR_D) begin
                        kind_in = pcsp_pkg::KIND_DIGITAL;
                     end else if (item.rx_byte == pcsp_pkg::CHAR_A) begin
                        kind_in = pcsp_pkg::KIND_ANALOG;
                     end else begin
                        kind_in = pcsp_pkg::KIND_VIRTUAL;
                     end
                     phase_in   = PH_ADDR;
                     addr_in    = 8'd0;
                     value_in   = 16'd0;
                     minus_in   = 1'b0;
                     digit_in   = 1'b0;
                     timer_in   = 1'b1;
                     elapsed_in = 16'd0;
                  end
               end
            endcase
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= pcsp_pkg::KIND_DIGITAL;
         addr_ff    <= 8'd0;
         value_ff   <= 16'd0;
         minus_ff   <= 1'b0;
         digit_ff   <= 1'b0;
         timer_ff   <= 1'b0;
         elapsed_ff <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         addr_ff    <= addr_in;
         value_ff   <= value_in;
         minus_ff   <= minus_in;
         digit_ff   <= digit_in;
         timer_ff   <= timer_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

>>> hdl/pin_command_stream_parser_unit.sv
// Top level of the pin command stream parser: input register, parser,
// result register and configuration port. Depends on pcsp_pkg, pcsp_csr, pcsp_parser.
`timescale 1ns / 1ps

// Pin command stream parser. Feed received bytes (opcode 0) and millisecond
// ticks (opcode 1) on the req_ channel; each completed <type><address>#<value>*
// command, or an expired timeout, comes out as one rsp_ transaction. The
// block takes one transaction per cycle while no result stalls on rsp_. A
// transaction is held in the input register, and the parser's state update
// writes the result register from it, which drives rsp_. A result held by
// rsp_ready low stalls the parser, and once the input register is also full
// req_ready drops. The timeout limit sits at byte address 0 of the csr_ port
// and should be written only while the block is idle.
module pin_command_stream_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_result_kind,
   output logic [7:0]                         rsp_pin_number,
   output logic signed [15:0]                 rsp_pin_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcsp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic                      in_valid_ff, in_valid_in;
   pcsp_pkg::pcsp_item_type   in_item_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [1:0]                out_kind_ff;
   logic [7:0]                out_addr_ff;
   logic [15:0]               out_value_ff;
   logic                      advance;
   logic [15:0]               timeout_ticks;
   pcsp_pkg::pcsp_result_type result;

   pcsp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   // Advance when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   pcsp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ticks),
      .result        (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture input and result payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.opcode  <= req_opcode;
         in_item_ff.rx_byte <= req_rx_byte;
      end
      if (advance && result.valid) begin
         out_kind_ff  <= result.result_kind;
         out_addr_ff  <= result.pin_number;
         out_value_ff <= result.pin_data;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_pin_number  = out_addr_ff;
   assign rsp_pin_data    = $signed(out_value_ff);

endmodule

>>> hdl/pcsp_checker.sv
// Port-level checks for the pin command stream parser, bound to the top
// level. Depends on pcsp_pkg and pin_command_stream_parser_unit.
`timescale 1ns / 1ps

module pcsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_result_kind,
   input logic [7:0]         rsp_pin_number,
   input logic signed [15:0] rsp_pin_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_pin_number) && $stable(rsp_pin_data))
      else $error("stalled result changed or dropped");

   // Drop any pending result on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Timeout carries zero address and value
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == pcsp_pkg::KIND_TIMEOUT) |->
      (rsp_pin_number == 8'd0) && (rsp_pin_data == 16'sd0))
      else $error("timeout result with nonzero payload");

   // Clamp analog values at the top
   a_analog_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == pcsp_pkg::KIND_ANALOG) |->
      (rsp_pin_data <= 16'sd255))
      else $error("analog value above clamp");

endmodule

bind pin_command_stream_parser_unit pcsp_checker u_pcsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_pin_number  (rsp_pin_number),
   .rsp_pin_data    (rsp_pin_data)
);
